### design/rri_pkg.sv
// Shared types and constants for the ray / rectangle intersection block.
// No dependencies; used by ray_rectangle_intersect_top.
package rri_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER_X    = 3'd0,
		REG_CENTER_Y    = 3'd1,
		REG_CENTER_Z    = 3'd2,
		REG_RECT_WIDTH  = 3'd3,
		REG_RECT_HEIGHT = 3'd4,
		REG_PLANE_AXIS  = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic signed [31:0] origin_x;
		logic signed [31:0] origin_y;
		logic signed [31:0] origin_z;
		logic signed [31:0] dir_x;
		logic signed [31:0] dir_y;
		logic signed [31:0] dir_z;
	} ray_t;

	typedef struct packed {
		logic               hit;
		logic        [30:0] distance;
		logic signed [31:0] impact_x;
		logic signed [31:0] impact_y;
		logic signed [31:0] impact_z;
		logic               normal_axis;
		logic        [30:0] tex_u;
		logic        [30:0] tex_v;
	} result_t;

endpackage

### design/rri_div.sv
// Pipelined restoring divider, one quotient bit per stage, saturating quotient.
// Carries a side payload alongside. Uses no package items.
module rri_div #(
	parameter int NW = 49,
	parameter int DW = 32,
	parameter int QW = 31,
	parameter int SW = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	input  logic [SW-1:0] side_in,
	output logic          out_valid,
	output logic [QW-1:0] quot,
	output logic [SW-1:0] side_out
);

	logic          valid_s [0:QW];
	logic [DW-1:0] rem_s   [0:QW];
	logic [QW-1:0] nlo_s   [0:QW];
	logic [QW-1:0] q_s     [0:QW];
	logic [DW-1:0] den_s   [0:QW];
	logic          ovf_s   [0:QW];
	logic [SW-1:0] side_s  [0:QW];

	// entry: top part of the dividend and the overflow check
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		rem_s[0]  <= DW'(num >> QW);
		nlo_s[0]  <= num[QW-1:0];
		q_s[0]    <= '0;
		den_s[0]  <= den;
		ovf_s[0]  <= (num >> QW) >= NW'(den);
		side_s[0] <= side_in;
	end

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [DW:0]   trial;
		logic          ge;
		logic [DW:0]   diff;

		assign trial = {rem_s[k-1], nlo_s[k-1][QW-k]};
		assign ge    = trial >= {1'b0, den_s[k-1]};
		assign diff  = trial - {1'b0, den_s[k-1]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k]  <= ge ? diff[DW-1:0] : trial[DW-1:0];
			nlo_s[k]  <= nlo_s[k-1];
			q_s[k]    <= q_s[k-1] | (QW'(ge) << (QW-k));
			den_s[k]  <= den_s[k-1];
			ovf_s[k]  <= ovf_s[k-1];
			side_s[k] <= side_s[k-1];
		end
	end

	assign out_valid = valid_s[QW];
	assign quot      = ovf_s[QW] ? '1 : q_s[QW];
	assign side_out  = side_s[QW];

endmodule

### design/ray_rectangle_intersect_top.sv
// Ray / axis-aligned rectangle (z-plane or y-plane) test, Q-format; uses rri_pkg, rri_div.
// From the start beat to the done strobe: s1, distance divider, s2, s3, s4, texture
// dividers, output register. Throughput one ray per cycle, set by the fully pipelined
// dividers (one quotient bit per stage). busy is always low; done cannot be stalled.
// Reset (arst_n, async, active low) clears all pipeline valid bits and loads
// the register defaults: centers 0, width and height 1.0, z-plane.
module ray_rectangle_intersect_top #(
	parameter int FRAC_BITS = rri_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  rri_pkg::ray_t                     ray,
	output logic                              done,
	output rri_pkg::result_t                  result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rri_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);

	// width of the unsaturated impact coordinates
	localparam int IX_W   = 66 - FRAC_BITS;
	localparam int TD_W   = IX_W + 1;             // texture offset magnitude
	localparam int N1_W   = 33 + FRAC_BITS;       // distance dividend
	localparam int NT_W   = TD_W + FRAC_BITS;     // texture dividend
	localparam int SIDE1_W = 1 + $bits(rri_pkg::ray_t);
	localparam int SIDEU_W = 1 + 31 + 96;
	localparam logic [30:0] ONE_FX = 31'(1) << FRAC_BITS;

	// ---------------- configuration registers ----------------
	logic signed [31:0] center_x_q, center_y_q, center_z_q;
	logic        [30:0] rect_width_q, rect_height_q;
	logic               plane_axis_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= '0;
			center_y_q    <= '0;
			center_z_q    <= '0;
			rect_width_q  <= ONE_FX;
			rect_height_q <= ONE_FX;
			plane_axis_q  <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (rri_pkg::cfg_idx_t'(cfg_index))
				rri_pkg::REG_CENTER_X:    center_x_q    <= cfg_data;
				rri_pkg::REG_CENTER_Y:    center_y_q    <= cfg_data;
				rri_pkg::REG_CENTER_Z:    center_z_q    <= cfg_data;
				rri_pkg::REG_RECT_WIDTH:  rect_width_q  <= cfg_data[30:0];
				rri_pkg::REG_RECT_HEIGHT: rect_height_q <= cfg_data[30:0];
				rri_pkg::REG_PLANE_AXIS:  plane_axis_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// never refuses a ray
	assign busy = 1'b0;

	// ---------------- s1: numerator / denominator on the plane axis ----------------
	logic signed [32:0] num_c;
	logic signed [31:0] den_c;
	logic        [32:0] num_mag_c;
	logic        [31:0] den_mag_c;

	always_comb begin
		if (plane_axis_q) begin
			num_c = 33'(center_y_q) - 33'(ray.origin_y);
			den_c = ray.dir_y;
		end else begin
			num_c = 33'(center_z_q) - 33'(ray.origin_z);
			den_c = ray.dir_z;
		end
		num_mag_c = num_c[32] ? 33'(-num_c) : 33'(num_c);
		den_mag_c = den_c[31] ? 32'(-den_c) : 32'(den_c);
	end

	logic                v_s1;
	rri_pkg::ray_t       ray_s1;
	logic        [32:0]  num_mag_s1;
	logic        [31:0]  den_mag_s1;
	logic                miss_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
		end
	end

	// wrong sign or zero direction is a miss; a zero quotient is caught after the divide
	always_ff @(posedge clk) begin
		ray_s1     <= ray;
		num_mag_s1 <= num_mag_c;
		den_mag_s1 <= den_mag_c;
		miss_s1    <= (den_c == '0) || (num_c[32] != den_c[31]);
	end

	// ---------------- distance divider ----------------
	logic                 v_d1;
	logic [30:0]          q_d1;
	logic [SIDE1_W-1:0]   side_d1;
	rri_pkg::ray_t        ray_d1;
	logic                 miss_d1;

	rri_div #(
		.NW(N1_W), .DW(32), .QW(31), .SW(SIDE1_W)
	) u_div_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s1),
		.num      ({num_mag_s1, {FRAC_BITS{1'b0}}}),
		.den      (den_mag_s1),
		.side_in  ({miss_s1, ray_s1}),
		.out_valid(v_d1),
		.quot     (q_d1),
		.side_out (side_d1)
	);

	assign {miss_d1, ray_d1} = side_d1;

	// ---------------- s2: |dir| * distance ----------------
	logic [31:0] adx_c, ady_c, adz_c;
	assign adx_c = ray_d1.dir_x[31] ? 32'(-ray_d1.dir_x) : 32'(ray_d1.dir_x);
	assign ady_c = ray_d1.dir_y[31] ? 32'(-ray_d1.dir_y) : 32'(ray_d1.dir_y);
	assign adz_c = ray_d1.dir_z[31] ? 32'(-ray_d1.dir_z) : 32'(ray_d1.dir_z);

	logic               v_s2;
	logic               miss_s2;
	logic        [30:0] dist_s2;
	logic        [62:0] px_s2, py_s2, pz_s2;
	logic               sx_s2, sy_s2, sz_s2;
	logic signed [31:0] ox_s2, oy_s2, oz_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		miss_s2 <= miss_d1 || (q_d1 == '0);
		dist_s2 <= q_d1;
		px_s2   <= 63'(adx_c) * 63'(q_d1);
		py_s2   <= 63'(ady_c) * 63'(q_d1);
		pz_s2   <= 63'(adz_c) * 63'(q_d1);
		sx_s2   <= ray_d1.dir_x[31];
		sy_s2   <= ray_d1.dir_y[31];
		sz_s2   <= ray_d1.dir_z[31];
		ox_s2   <= ray_d1.origin_x;
		oy_s2   <= ray_d1.origin_y;
		oz_s2   <= ray_d1.origin_z;
	end

	// ---------------- s3: impact point, full width ----------------
	logic signed [IX_W-1:0] stx_c, sty_c, stz_c;
	assign stx_c = sx_s2 ? -$signed(IX_W'(px_s2 >> FRAC_BITS))
	                     :  $signed(IX_W'(px_s2 >> FRAC_BITS));
	assign sty_c = sy_s2 ? -$signed(IX_W'(py_s2 >> FRAC_BITS))
	                     :  $signed(IX_W'(py_s2 >> FRAC_BITS));
	assign stz_c = sz_s2 ? -$signed(IX_W'(pz_s2 >> FRAC_BITS))
	                     :  $signed(IX_W'(pz_s2 >> FRAC_BITS));

	logic                   v_s3;
	logic                   miss_s3;
	logic            [30:0] dist_s3;
	logic signed [IX_W-1:0] ix_s3, iy_s3, iz_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		miss_s3 <= miss_s2;
		dist_s3 <= dist_s2;
		ix_s3   <= IX_W'(ox_s2) + stx_c;
		iy_s3   <= IX_W'(oy_s2) + sty_c;
		iz_s3   <= IX_W'(oz_s2) + stz_c;
	end

	// ---------------- s4: bounds, saturation, texture offsets ----------------
	function automatic logic signed [31:0] sat32(input logic signed [IX_W-1:0] v);
		logic signed [IX_W-1:0] hi, lo;
		hi = IX_W'(32'sh7fffffff);
		lo = IX_W'(-33'sh080000000);
		if (v > hi) begin
			sat32 = 32'sh7fffffff;
		end else if (v < lo) begin
			sat32 = 32'sh80000000;
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	logic signed [32:0] hw_c, hh_c;
	logic signed [32:0] xlo_c, xhi_c, ylo_c, yhi_c, zlo_c, zhi_c, ulo_c;
	logic               in_x_c, in_y_c, in_z_c;
	logic signed [TD_W-1:0] du_c, dv_c;

	assign hw_c  = 33'({1'b0, rect_width_q[30:1]});
	assign hh_c  = 33'({1'b0, rect_height_q[30:1]});
	assign xlo_c = 33'(center_x_q) - hw_c;
	assign xhi_c = 33'(center_x_q) + hw_c;
	assign ylo_c = 33'(center_y_q) - hh_c;
	assign yhi_c = 33'(center_y_q) + hh_c;
	assign zlo_c = 33'(center_z_q) - hh_c;
	assign zhi_c = 33'(center_z_q) + hh_c;
	// v offset uses the half width on y, as the texture mapping defines it
	assign ulo_c = 33'(center_y_q) - hw_c;

	assign in_x_c = (ix_s3 <= IX_W'(xhi_c)) && (ix_s3 >= IX_W'(xlo_c));
	assign in_y_c = (iy_s3 <= IX_W'(yhi_c)) && (iy_s3 >= IX_W'(ylo_c));
	assign in_z_c = (iz_s3 <= IX_W'(zhi_c)) && (iz_s3 >= IX_W'(zlo_c));

	assign du_c = TD_W'(ix_s3) - TD_W'(xlo_c);
	assign dv_c = TD_W'(iy_s3) - TD_W'(ulo_c);

	logic               v_s4;
	logic               hit_s4;
	logic        [30:0] dist_s4;
	logic signed [31:0] ix_s4, iy_s4, iz_s4;
	logic [TD_W-1:0]    du_s4, dv_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		hit_s4  <= !miss_s3 && in_x_c && in_y_c && in_z_c;
		dist_s4 <= dist_s3;
		ix_s4   <= sat32(ix_s3);
		iy_s4   <= sat32(iy_s3);
		iz_s4   <= sat32(iz_s3);
		du_s4   <= du_c[TD_W-1] ? TD_W'(-du_c) : TD_W'(du_c);
		dv_s4   <= dv_c[TD_W-1] ? TD_W'(-dv_c) : TD_W'(dv_c);
	end

	// ---------------- texture dividers (both by width) ----------------
	logic               v_du, v_dv;
	logic [30:0]        q_du, q_dv;
	logic [SIDEU_W-1:0] side_du;
	logic               axis_dv;
	logic               hit_o;
	logic [30:0]        dist_o;
	logic signed [31:0] ix_o, iy_o, iz_o;

	rri_div #(
		.NW(NT_W), .DW(31), .QW(31), .SW(SIDEU_W)
	) u_div_u (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.num      ({du_s4, {FRAC_BITS{1'b0}}}),
		.den      (rect_width_q),
		.side_in  ({hit_s4, dist_s4, ix_s4, iy_s4, iz_s4}),
		.out_valid(v_du),
		.quot     (q_du),
		.side_out (side_du)
	);

	rri_div #(
		.NW(NT_W), .DW(31), .QW(31), .SW(1)
	) u_div_v (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (v_s4),
		.num      ({dv_s4, {FRAC_BITS{1'b0}}}),
		.den      (rect_width_q),
		.side_in  (plane_axis_q),
		.out_valid(v_dv),
		.quot     (q_dv),
		.side_out (axis_dv)
	);

	assign {hit_o, dist_o, ix_o, iy_o, iz_o} = side_du;

	// ---------------- output register: misses come out all zero ----------------
	logic             done_q;
	rri_pkg::result_t result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= v_du && v_dv;
		end
	end

	always_ff @(posedge clk) begin
		if (hit_o) begin
			result_q.hit         <= 1'b1;
			result_q.distance    <= dist_o;
			result_q.impact_x    <= ix_o;
			result_q.impact_y    <= iy_o;
			result_q.impact_z    <= iz_o;
			result_q.normal_axis <= axis_dv;
			result_q.tex_u       <= q_du;
			result_q.tex_v       <= q_dv;
		end else begin
			result_q <= '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule
